/* design/amgsu_pkg.sv */
// amgsu_pkg: shared constants and codes of the graph search unit.
// No dependencies; imported by every module of the block.
package amgsu_pkg;

   localparam int MAX_VERTICES_DEF = 32;
   localparam int ID_BITS_DEF      = 32;

   localparam int ACT_W  = 3;
   localparam int CNT_W  = 6;
   localparam int EDGE_W = 16;
   localparam int STAT_W = 2;
   localparam int VID_W  = 32;

   typedef enum logic [ACT_W-1:0] {
      ACT_ADD_VERTEX = 3'd0,
      ACT_ADD_EDGE   = 3'd1,
      ACT_EDGE_QUERY = 3'd2,
      ACT_DEGREE     = 3'd3,
      ACT_DEPTH      = 3'd4,
      ACT_BREADTH    = 3'd5,
      ACT_CLEAR      = 3'd6,
      ACT_UNUSED     = 3'd7
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FOUND = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

endpackage

/* design/amgsu_ram.sv */
// amgsu_ram: simple dual-port RAM, one write and one registered read port.
// Depends on amgsu_pkg for the default WIDTH and DEPTH.
module amgsu_ram
   import amgsu_pkg::*;
#(
   parameter int WIDTH = ID_BITS_DEF,
   parameter int DEPTH = MAX_VERTICES_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/adjacency_matrix_graph_search_unit.sv */
// adjacency_matrix_graph_search_unit: directed graph store with edge/degree
// queries and depth-first / breadth-first search. Uses amgsu_pkg, amgsu_ram.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_ready | action, vertex_id, second_id
//  rsp     | out       | rsp_valid/rsp_ready | is_visit .. last (8 fields)
//
// Id lookup scans the id table one entry a cycle through one comparator, ending
// on a hit or after all n stored vertices. After accept and lookup: add vertex
// writes the id table; edge add/query reads the row, then sets or tests one bit;
// out-degree counts the row's bits. A search pops a vertex, reads its id and row,
// emits the visit, then scans the row. Reset and clear empty the graph via the
// vertex count and row valid bits. One item at a time; a waiting result does not
// stop the next item's work until that item itself needs the output register.
module adjacency_matrix_graph_search_unit
   import amgsu_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int ID_BITS      = ID_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [ACT_W-1:0]   req_action,
   input  logic [ID_BITS-1:0] req_vertex_id,
   input  logic [ID_BITS-1:0] req_second_id,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_is_visit,
   output logic [VID_W-1:0]   rsp_visited_id,
   output logic               rsp_edge_exists,
   output logic [CNT_W-1:0]   rsp_out_degree,
   output logic [CNT_W-1:0]   rsp_vertex_count,
   output logic [EDGE_W-1:0]  rsp_edge_count,
   output logic [STAT_W-1:0]  rsp_status,
   output logic               rsp_last
);

   localparam int VI = $clog2(MAX_VERTICES);
   localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_VERTICES);
   localparam logic [MAX_VERTICES-1:0] ONE_ROW = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

   typedef enum logic [3:0] {
      S_IDLE, S_LOOK, S_EXEC, S_ROW_WAIT, S_DEG, S_POP, S_POP_WAIT,
      S_VISIT, S_SCAN, S_FIN
   } state_type;

   state_type state_ff, state_in;
   action_type act_ff, act_in;
   logic [ID_BITS-1:0] a_ff, a_in, b_ff, b_in;
   logic lk_b_ff, lk_b_in, pv_ff, pv_in;
   logic [VI-1:0] pidx_ff, pidx_in, fi_ff, fi_in, ti_ff, ti_in, v_ff, v_in;
   logic fok_ff, fok_in, tok_ff, tok_in;
   logic [CNT_W-1:0] idx_ff, idx_in, cnt_ff, cnt_in, head_ff, head_in;
   logic [CNT_W-1:0] tail_ff, tail_in, deg_ff, deg_in;
   logic [EDGE_W-1:0] edges_ff, edges_in;
   logic [MAX_VERTICES-1:0] marks_ff, marks_in, rowv_ff, rowv_in, row_ff, row_in;
   logic adj_ok_ff, adj_ok_in, exists_ff, exists_in;
   status_type status_ff, status_in;

   logic rv_ff, rv_in, rvis_ff, rvis_in, rex_ff, rex_in, rlast_ff, rlast_in;
   logic [VID_W-1:0] rvid_ff, rvid_in;
   logic [CNT_W-1:0] rdeg_ff, rdeg_in, rcnt_ff, rcnt_in;
   logic [EDGE_W-1:0] redg_ff, redg_in;
   logic [STAT_W-1:0] rst_ff, rst_in;

   // memory ports
   logic id_we, id_re, adj_we, adj_re, pd_we, pd_re;
   logic [VI-1:0] id_wa, id_ra, adj_wa, adj_ra, pd_wa, pd_ra;
   logic [ID_BITS-1:0] id_wd, id_rd;
   logic [MAX_VERTICES-1:0] adj_wd, adj_rd;
   logic [VI-1:0] pd_wd, pd_rd;

   amgsu_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_VERTICES)) u_id (
      .clock(clock), .wr_en(id_we), .wr_addr(id_wa), .wr_data(id_wd),
      .rd_en(id_re), .rd_addr(id_ra), .rd_data(id_rd));
   amgsu_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
      .clock(clock), .wr_en(adj_we), .wr_addr(adj_wa), .wr_data(adj_wd),
      .rd_en(adj_re), .rd_addr(adj_ra), .rd_data(adj_rd));
   amgsu_ram #(.WIDTH(VI), .DEPTH(MAX_VERTICES)) u_pend (
      .clock(clock), .wr_en(pd_we), .wr_addr(pd_wa), .wr_data(pd_wd),
      .rd_en(pd_re), .rd_addr(pd_ra), .rd_data(pd_rd));

   logic slot_free, search, need_b, hit, lk_done;
   logic [ID_BITS-1:0] key;
   logic [MAX_VERTICES-1:0] row_now;
   logic [CNT_W-1:0] tail_dec;
   logic [VI-1:0] j;

   assign slot_free = !rv_ff || rsp_ready;
   assign search    = (act_ff == ACT_DEPTH) || (act_ff == ACT_BREADTH);
   assign need_b    = search || (act_ff == ACT_ADD_EDGE) || (act_ff == ACT_EDGE_QUERY);
   assign key       = lk_b_ff ? b_ff : a_ff;
   assign hit       = pv_ff && (id_rd == key) && (key != '0);
   assign lk_done   = (key == '0) || hit || ((idx_ff >= cnt_ff) && !pv_ff);
   // a row never written since the last clear reads as empty
   assign row_now   = adj_ok_ff ? adj_rd : '0;
   assign tail_dec  = tail_ff - CNT_W'(1);
   assign j         = idx_ff[VI-1:0];

   always_comb begin
      state_in = state_ff; act_in = act_ff; a_in = a_ff; b_in = b_ff;
      lk_b_in = lk_b_ff; pv_in = pv_ff; pidx_in = pidx_ff;
      fi_in = fi_ff; ti_in = ti_ff; v_in = v_ff; fok_in = fok_ff; tok_in = tok_ff;
      idx_in = idx_ff; cnt_in = cnt_ff; head_in = head_ff; tail_in = tail_ff;
      deg_in = deg_ff; edges_in = edges_ff; marks_in = marks_ff; rowv_in = rowv_ff;
      row_in = row_ff; adj_ok_in = adj_ok_ff; exists_in = exists_ff;
      status_in = status_ff;
      rv_in = rv_ff && !rsp_ready; rvis_in = rvis_ff; rvid_in = rvid_ff;
      rex_in = rex_ff; rdeg_in = rdeg_ff; rcnt_in = rcnt_ff; redg_in = redg_ff;
      rst_in = rst_ff; rlast_in = rlast_ff;
      id_we = 1'b0; id_wa = cnt_ff[VI-1:0]; id_wd = a_ff;
      id_re = 1'b0; id_ra = idx_ff[VI-1:0];
      adj_we = 1'b0; adj_wa = fi_ff; adj_wd = row_now | (ONE_ROW << ti_ff);
      adj_re = 1'b0; adj_ra = fi_ff;
      pd_we = 1'b0; pd_wa = tail_ff[VI-1:0]; pd_wd = j;
      pd_re = 1'b0; pd_ra = head_ff[VI-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in = action_type'(req_action);
               a_in = req_vertex_id; b_in = req_second_id;
               lk_b_in = 1'b0; pv_in = 1'b0; idx_in = '0;
               exists_in = 1'b0; deg_in = '0; status_in = ST_OK;
               fok_in = 1'b0; tok_in = 1'b0;
               state_in = S_LOOK;
               if (action_type'(req_action) == ACT_CLEAR) begin
                  cnt_in = '0; edges_in = '0; marks_in = '0; rowv_in = '0;
                  head_in = '0; tail_in = '0;
                  state_in = S_FIN;
               end else if (action_type'(req_action) == ACT_UNUSED) begin
                  status_in = ST_ERROR;
                  state_in = S_FIN;
               end
            end
         end
         S_LOOK: begin
            if (lk_done) begin
               if (!lk_b_ff) begin
                  fok_in = hit; fi_in = pidx_ff;
               end else begin
                  tok_in = hit; ti_in = pidx_ff;
               end
               if (!lk_b_ff && need_b && hit) begin
                  lk_b_in = 1'b1; pv_in = 1'b0; idx_in = '0;
               end else begin
                  state_in = S_EXEC;
               end
            end else if (idx_ff < cnt_ff) begin
               id_re = 1'b1; pv_in = 1'b1; pidx_in = j; idx_in = idx_ff + CNT_W'(1);
            end else begin
               pv_in = 1'b0;
            end
         end
         S_EXEC: begin
            state_in = S_FIN;
            case (act_ff)
               ACT_ADD_VERTEX: begin
                  if (a_ff == '0) begin
                     status_in = ST_ERROR;
                  end else if (!fok_ff) begin
                     if (cnt_ff >= MAXC) begin
                        status_in = ST_ERROR;
                     end else begin
                        id_we = 1'b1; cnt_in = cnt_ff + CNT_W'(1);
                     end
                  end
               end
               ACT_ADD_EDGE: begin
                  if (!(fok_ff && tok_ff)) begin
                     status_in = ST_ERROR;
                  end else begin
                     if (edges_ff != '1) edges_in = edges_ff + EDGE_W'(1);
                     adj_re = 1'b1; adj_ok_in = rowv_ff[fi_ff]; state_in = S_ROW_WAIT;
                  end
               end
               ACT_EDGE_QUERY: begin
                  if (fok_ff && tok_ff) begin
                     adj_re = 1'b1; adj_ok_in = rowv_ff[fi_ff]; state_in = S_ROW_WAIT;
                  end
               end
               ACT_DEGREE: begin
                  if (!fok_ff) begin
                     status_in = ST_ERROR;
                  end else begin
                     adj_re = 1'b1; adj_ok_in = rowv_ff[fi_ff]; state_in = S_ROW_WAIT;
                  end
               end
               ACT_DEPTH, ACT_BREADTH: begin
                  if (!(fok_ff && tok_ff)) begin
                     status_in = ST_ERROR;
                  end else begin
                     marks_in = ONE_ROW << fi_ff;
                     head_in = '0; tail_in = CNT_W'(1);
                     pd_we = 1'b1; pd_wa = '0; pd_wd = fi_ff;
                     state_in = S_POP;
                  end
               end
               default: status_in = ST_ERROR;
            endcase
         end
         S_ROW_WAIT: begin
            state_in = S_FIN;
            case (act_ff)
               ACT_ADD_EDGE: begin
                  adj_we = 1'b1; rowv_in[fi_ff] = 1'b1;
               end
               ACT_EDGE_QUERY: exists_in = row_now[ti_ff];
               default: begin
                  row_in = row_now; idx_in = '0; state_in = S_DEG;
               end
            endcase
         end
         S_DEG: begin
            if (idx_ff < cnt_ff) begin
               deg_in = deg_ff + CNT_W'(row_ff[j]);
               idx_in = idx_ff + CNT_W'(1);
            end else begin
               state_in = S_FIN;
            end
         end
         S_POP: begin
            if (tail_ff > head_ff) begin
               pd_re = 1'b1;
               if (act_ff == ACT_DEPTH) begin
                  pd_ra = tail_dec[VI-1:0]; tail_in = tail_dec;
               end else begin
                  head_in = head_ff + CNT_W'(1);
               end
               state_in = S_POP_WAIT;
            end else begin
               status_in = ST_OK; state_in = S_FIN;
            end
         end
         S_POP_WAIT: begin
            v_in = pd_rd;
            id_re = 1'b1; id_ra = pd_rd;
            adj_re = 1'b1; adj_ra = pd_rd; adj_ok_in = rowv_ff[pd_rd];
            state_in = S_VISIT;
         end
         S_VISIT: begin
            if (slot_free) begin
               rv_in = 1'b1; rvis_in = 1'b1; rvid_in = VID_W'(id_rd);
               rex_in = 1'b0; rdeg_in = '0; rcnt_in = cnt_ff; redg_in = edges_ff;
               rst_in = ST_OK; rlast_in = 1'b0;
               if (v_ff == ti_ff) begin
                  status_in = ST_FOUND; state_in = S_FIN;
               end else begin
                  row_in = row_now; idx_in = '0; state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (idx_ff < cnt_ff) begin
               if (row_ff[j] && !marks_ff[j]) begin
                  marks_in[j] = 1'b1;
                  if (tail_ff < MAXC) begin
                     pd_we = 1'b1; tail_in = tail_ff + CNT_W'(1);
                  end
               end
               idx_in = idx_ff + CNT_W'(1);
            end else begin
               state_in = S_POP;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               rv_in = 1'b1; rvis_in = 1'b0; rvid_in = '0;
               rex_in = exists_ff; rdeg_in = deg_ff; rcnt_in = cnt_ff;
               redg_in = edges_ff; rst_in = status_ff; rlast_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; edges_ff <= '0; marks_ff <= '0;
         rowv_ff <= '0; head_ff <= '0; tail_ff <= '0; rv_ff <= 1'b0;
         lk_b_ff <= 1'b0; pv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; edges_ff <= edges_in;
         marks_ff <= marks_in; rowv_ff <= rowv_in; head_ff <= head_in;
         tail_ff <= tail_in; rv_ff <= rv_in; lk_b_ff <= lk_b_in; pv_ff <= pv_in;
      end
      act_ff <= act_in; a_ff <= a_in; b_ff <= b_in; pidx_ff <= pidx_in;
      fi_ff <= fi_in; ti_ff <= ti_in; v_ff <= v_in; fok_ff <= fok_in;
      tok_ff <= tok_in; idx_ff <= idx_in; deg_ff <= deg_in; row_ff <= row_in;
      adj_ok_ff <= adj_ok_in; exists_ff <= exists_in; status_ff <= status_in;
      rvis_ff <= rvis_in; rvid_ff <= rvid_in; rex_ff <= rex_in; rdeg_ff <= rdeg_in;
      rcnt_ff <= rcnt_in; redg_ff <= redg_in; rst_ff <= rst_in; rlast_ff <= rlast_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rv_ff;
   assign rsp_is_visit     = rvis_ff;
   assign rsp_visited_id   = rvid_ff;
   assign rsp_edge_exists  = rex_ff;
   assign rsp_out_degree   = rdeg_ff;
   assign rsp_vertex_count = rcnt_ff;
   assign rsp_edge_count   = redg_ff;
   assign rsp_status       = rst_ff;
   assign rsp_last         = rlast_ff;

endmodule

/* design/amgsu_checker.sv */
// amgsu_checker: port-level assertions for the graph search unit.
// Uses amgsu_pkg; bound to adjacency_matrix_graph_search_unit below.
module amgsu_checker
   import amgsu_pkg::*;
#(
   parameter int ID_BITS = ID_BITS_DEF
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [ACT_W-1:0]   req_action,
   input logic [ID_BITS-1:0] req_vertex_id,
   input logic [ID_BITS-1:0] req_second_id,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_is_visit,
   input logic [VID_W-1:0]   rsp_visited_id,
   input logic               rsp_edge_exists,
   input logic [CNT_W-1:0]   rsp_out_degree,
   input logic [CNT_W-1:0]   rsp_vertex_count,
   input logic [EDGE_W-1:0]  rsp_edge_count,
   input logic [STAT_W-1:0]  rsp_status,
   input logic               rsp_last
);

   // not ready in the cycle after taking a beat
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready straight after accept");

   // every result that is not the last one is a visit
   a_visit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_visit != rsp_last))
      else $error("visit and last flags disagree");

   // visits carry ok status and no query answers
   a_vfields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_visit |->
         rsp_status == ST_OK && !rsp_edge_exists && rsp_out_degree == '0)
      else $error("visit beat with stray fields");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_visited_id)
         && $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind adjacency_matrix_graph_search_unit amgsu_checker #(.ID_BITS(ID_BITS)) u_chk (.*);
